// ===== hdl/box_blur_3x3_rgb_top_defines.svh =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top_defines.svh
// Assertion macros used by the box blur top level. Clock clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// same-cycle implication
`define BBLUR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBLUR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg
// Types, constants and the reciprocal table of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int WIN_SIDE    = 3;
  localparam int WIN_N       = 9;
  localparam int SUM_W       = 12;   // 9 * 255 fits
  localparam int CNT_W       = 4;
  localparam int RCP_W       = 17;
  localparam int RCP_SH      = 16;
  localparam int IMG_W_REG_W = 11;
  localparam int IMG_H_REG_W = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int ROW_W       = 14;   // row runs to height + 1 while draining
  localparam int WIDTH_RST   = 640;
  localparam int HEIGHT_RST  = 480;
  localparam int CQ_DEPTH    = 4;
  localparam int OQ_DEPTH    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMG_WIDTH  = 1'b0,
    REG_IMG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // one column of the window plus what the back end needs to finish it
  typedef struct packed {
    pix_t             top;
    pix_t             mid;
    pix_t             bot;
    logic [WIN_N-1:0] mask;
    logic             emit;
    logic             last;
  } col_entry_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } res_t;

  // ceil(2^16 / n): exact truncated quotient for sums up to 9 * 255
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/bblur_fifo.sv =====
// ----------------------------------------------------------------------------
// bblur_fifo
// Small register FIFO with occupancy count, used for both internal queues.
// ----------------------------------------------------------------------------
module bblur_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// ===== hdl/bblur_front.sv =====
// ----------------------------------------------------------------------------
// bblur_front
// Accepts items, tracks frame position, runs the two line buffers and tags
// each column with its border mask before handing it to the column queue.
// ----------------------------------------------------------------------------
module bblur_front #(
  parameter int MAX_LINE = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                   in_push_i,
  output logic                                   in_full_o,
  input  logic                                   kind_i,
  input  bblur_pkg::pix_t                        pix_i,
  input  logic [$clog2(bblur_pkg::CQ_DEPTH+1)-1:0] cq_count_i,
  output logic                                   cq_push_o,
  output bblur_pkg::col_entry_t                  cq_data_o
);

  import bblur_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int WW    = $clog2(MAX_LINE + 1);
  localparam int RW1   = ROW_W + 1;
  localparam int QCW   = $clog2(CQ_DEPTH + 1) + 1;
  localparam int RST_W = (WIDTH_RST > MAX_LINE) ? MAX_LINE : WIDTH_RST;

  logic [WW-1:0]          eff_w_q;
  logic [IMG_H_REG_W-1:0] eff_h_q;
  logic [COL_W-1:0]       col_q;
  logic [ROW_W-1:0]       row_q;

  logic                   f1_v_q;
  logic [COL_W-1:0]       f1_col_q;
  pix_t                   f1_pix_q;
  logic [WIN_N-1:0]       f1_mask_q;
  logic                   f1_emit_q;
  logic                   f1_last_q;
  logic [2*PIX_W-1:0]     rd_q;
  logic                   fwd_hit_q;
  logic [2*PIX_W-1:0]     fwd_q;

  // entry: {older line, latest line}
  logic [2*PIX_W-1:0]     lbuf_q [MAX_LINE];

  logic [ROW_W-1:0]       h_ext;
  logic                   frame_done, drop, accept, take, col0, emit, last, wrap;
  pix_t                   pix_in;
  logic [RW1-1:0]         rlo, rhi;
  logic [WIN_SIDE-1:0]    rvalid, cvalid;
  logic [WIN_N-1:0]       mask;
  logic [WW-1:0]          c_inc;
  logic [2*PIX_W-1:0]     line;
  pix_t                   line_top, line_mid;
  logic [31:0]            w_raw, w_eff;
  logic [IMG_H_REG_W-1:0] h_raw;

  assign h_ext      = ROW_W'(eff_h_q);
  assign frame_done = (row_q >= h_ext);
  assign drop       = kind_i && !frame_done;
  assign in_full_o  = (QCW'(cq_count_i) + QCW'(f1_v_q)) >= QCW'(CQ_DEPTH);
  assign accept     = in_push_i && !in_full_o;
  assign take       = accept && !drop;
  assign pix_in     = frame_done ? '0 : pix_i;

  assign col0 = (col_q == '0);
  assign emit = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && !col0);
  assign last = emit && col0 && (row_q == h_ext + ROW_W'(1));

  // a line-start column finishes the previous line's right edge pixel
  assign rlo = col0 ? RW1'(3) : RW1'(2);
  assign rhi = {1'b0, h_ext} + rlo;

  always_comb begin
    for (int j = 0; j < WIN_SIDE; j++) begin
      rvalid[j] = (({1'b0, row_q} + RW1'(j)) >= rlo) && (({1'b0, row_q} + RW1'(j)) < rhi);
    end
    cvalid[0] = col0 ? (eff_w_q >= WW'(2)) : (WW'(col_q) >= WW'(2));
    cvalid[1] = 1'b1;
    cvalid[2] = !col0;
    for (int j = 0; j < WIN_SIDE; j++) begin
      for (int k = 0; k < WIN_SIDE; k++) begin
        mask[j*WIN_SIDE+k] = rvalid[j] & cvalid[k];
      end
    end
  end

  assign c_inc = WW'(col_q) + WW'(1);
  assign wrap  = (c_inc >= eff_w_q);

  // read data may miss the write of the column just before (width of one)
  assign line     = fwd_hit_q ? fwd_q : rd_q;
  assign line_top = line[2*PIX_W-1:PIX_W];
  assign line_mid = line[PIX_W-1:0];

  // config clamping
  assign w_raw = 32'(cfg_wdata_i[IMG_W_REG_W-1:0]);
  assign w_eff = (w_raw == 32'd0) ? 32'd1 : ((w_raw > 32'(MAX_LINE)) ? 32'(MAX_LINE) : w_raw);
  assign h_raw = cfg_wdata_i[IMG_H_REG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q   <= WW'(RST_W);
      eff_h_q   <= IMG_H_REG_W'(HEIGHT_RST);
      col_q     <= '0;
      row_q     <= '0;
      f1_v_q    <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      f1_v_q <= take;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_IMG_WIDTH: begin
            eff_w_q <= WW'(w_eff);
            col_q   <= '0;
            row_q   <= '0;
          end
          REG_IMG_HEIGHT: begin
            eff_h_q <= (h_raw == '0) ? IMG_H_REG_W'(1) : h_raw;
            col_q   <= '0;
            row_q   <= '0;
          end
          default: begin
          end
        endcase
      end else if (take) begin
        if (last) begin
          col_q <= '0;
          row_q <= '0;
        end else if (wrap) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (take) fwd_hit_q <= f1_v_q && (f1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      f1_col_q  <= col_q;
      f1_pix_q  <= pix_in;
      f1_mask_q <= mask;
      f1_emit_q <= emit;
      f1_last_q <= last;
      fwd_q     <= {line_mid, f1_pix_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) rd_q <= lbuf_q[col_q];
    if (f1_v_q) lbuf_q[f1_col_q] <= {line_mid, f1_pix_q};
  end

  assign cq_push_o      = f1_v_q;
  assign cq_data_o.top  = line_top;
  assign cq_data_o.mid  = line_mid;
  assign cq_data_o.bot  = f1_pix_q;
  assign cq_data_o.mask = f1_mask_q;
  assign cq_data_o.emit = f1_emit_q;
  assign cq_data_o.last = f1_last_q;

endmodule

// ===== hdl/bblur_back.sv =====
// ----------------------------------------------------------------------------
// bblur_back
// Shifts columns into the 3x3 window, sums the in-frame cells, divides by
// the cell count with a reciprocal multiply and queues the result.
// ----------------------------------------------------------------------------
module bblur_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cq_empty_i,
  input  bblur_pkg::col_entry_t cq_data_i,
  output logic                  cq_pop_o,
  input  logic                  out_pop_i,
  output logic                  out_empty_o,
  output bblur_pkg::res_t       res_o
);

  import bblur_pkg::*;

  localparam int OCW  = $clog2(OQ_DEPTH + 1);
  localparam int OCW1 = OCW + 1;
  localparam int PRW  = SUM_W + RCP_W;

  pix_t               win_q [WIN_N];
  logic               b1_v_q;
  logic [WIN_N-1:0]   b1_mask_q;
  logic               b1_emit_q;
  logic               b1_last_q;
  logic               b2_v_q;
  logic [SUM_W-1:0]   sum_r_q, sum_g_q, sum_b_q;
  logic [RCP_W-1:0]   rcp_q;
  logic               b2_last_q;

  logic [SUM_W-1:0]   sum_r_d, sum_g_d, sum_b_d;
  logic [PRW-1:0]     prod_r, prod_g, prod_b;
  logic [OCW-1:0]     oq_count;
  res_t               oq_wdata;

  // credit: everything in flight must fit in the output queue
  assign cq_pop_o = !cq_empty_i &&
                    ((OCW1'(oq_count) + OCW1'(b1_v_q) + OCW1'(b2_v_q)) < OCW1'(OQ_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cq_pop_o) begin
      for (int j = 0; j < WIN_SIDE; j++) begin
        win_q[j*WIN_SIDE]     <= win_q[j*WIN_SIDE+1];
        win_q[j*WIN_SIDE + 1] <= win_q[j*WIN_SIDE+2];
      end
      win_q[2]  <= cq_data_i.top;
      win_q[5]  <= cq_data_i.mid;
      win_q[8]  <= cq_data_i.bot;
      b1_mask_q <= cq_data_i.mask;
      b1_emit_q <= cq_data_i.emit;
      b1_last_q <= cq_data_i.last;
    end
    if (b1_v_q) begin
      sum_r_q   <= sum_r_d;
      sum_g_q   <= sum_g_d;
      sum_b_q   <= sum_b_d;
      rcp_q     <= recip(CNT_W'($countones(b1_mask_q)));
      b2_last_q <= b1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      b1_v_q <= cq_pop_o;
      b2_v_q <= b1_v_q && b1_emit_q;
    end
  end

  always_comb begin
    sum_r_d = '0;
    sum_g_d = '0;
    sum_b_d = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (b1_mask_q[i]) begin
        sum_r_d = sum_r_d + SUM_W'(win_q[i][3*CH_W-1 -: CH_W]);
        sum_g_d = sum_g_d + SUM_W'(win_q[i][2*CH_W-1 -: CH_W]);
        sum_b_d = sum_b_d + SUM_W'(win_q[i][CH_W-1 -: CH_W]);
      end
    end
  end

  assign prod_r = PRW'(sum_r_q) * PRW'(rcp_q);
  assign prod_g = PRW'(sum_g_q) * PRW'(rcp_q);
  assign prod_b = PRW'(sum_b_q) * PRW'(rcp_q);

  assign oq_wdata.red   = prod_r[RCP_SH +: CH_W];
  assign oq_wdata.green = prod_g[RCP_SH +: CH_W];
  assign oq_wdata.blue  = prod_b[RCP_SH +: CH_W];
  assign oq_wdata.last  = b2_last_q;

  bblur_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b2_v_q),
    .wdata_i (oq_wdata),
    .pop_i   (out_pop_i && !out_empty_o),
    .rdata_o (res_o),
    .empty_o (out_empty_o),
    .count_o (oq_count)
  );

endmodule

// ===== hdl/box_blur_3x3_rgb_top.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// 3x3 box blur over a raster-order RGB stream, per channel truncated mean
// of the in-frame neighbourhood.
//
// Channel  Dir  Handshake      Payload
// input    in   push / full    kind_i, red_in_i, green_in_i, blue_in_i
// result   out  empty / pop    red_out_o, green_out_o, blue_out_o, frame_end_o
// config   in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// One item per clock sustained unless full; the line buffer (one read, one
// write port) handles one column per cycle. Results pass the front stage,
// column queue, window, sums and output queue, one line plus one pixel late.
// Reset clears counters and queues; the line buffer needs no clearing pass.
// full is high while the column queue has no credit left; the back end stops
// when the output queue has no credit, the front keeps going until full.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
  parameter int MAX_LINE = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 kind_i,
  input  logic [bblur_pkg::CH_W-1:0]           red_in_i,
  input  logic [bblur_pkg::CH_W-1:0]           green_in_i,
  input  logic [bblur_pkg::CH_W-1:0]           blue_in_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [bblur_pkg::CH_W-1:0]           red_out_o,
  output logic [bblur_pkg::CH_W-1:0]           green_out_o,
  output logic [bblur_pkg::CH_W-1:0]           blue_out_o,
  output logic                                 frame_end_o
);

  import bblur_pkg::*;

  `include "box_blur_3x3_rgb_top_defines.svh"

  localparam int CQW = $clog2(CQ_DEPTH + 1);

  logic                      cq_push, cq_pop, cq_empty;
  col_entry_t                cq_wdata, cq_rdata;
  logic [$bits(col_entry_t)-1:0] cq_rvec;
  logic [CQW-1:0]            cq_count;
  res_t                      res;

  bblur_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_push_i   (push),
    .in_full_o   (full),
    .kind_i      (kind_i),
    .pix_i       ({red_in_i, green_in_i, blue_in_i}),
    .cq_count_i  (cq_count),
    .cq_push_o   (cq_push),
    .cq_data_o   (cq_wdata)
  );

  bblur_fifo #(
    .WIDTH ($bits(col_entry_t)),
    .DEPTH (CQ_DEPTH)
  ) u_col_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .wdata_i (cq_wdata),
    .pop_i   (cq_pop),
    .rdata_o (cq_rvec),
    .empty_o (cq_empty),
    .count_o (cq_count)
  );

  assign cq_rdata = col_entry_t'(cq_rvec);

  bblur_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cq_empty_i  (cq_empty),
    .cq_data_i   (cq_rdata),
    .cq_pop_o    (cq_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .res_o       (res)
  );

  assign red_out_o   = res.red;
  assign green_out_o = res.green;
  assign blue_out_o  = res.blue;
  assign frame_end_o = res.last;

  `BBLUR_ASSERT_IMP(a_cq_no_overflow, cq_push && !cq_pop, cq_count < CQW'(CQ_DEPTH), "column queue overflow")
  `BBLUR_ASSERT_IMP(a_cq_no_underflow, cq_pop, cq_count != '0, "column queue underflow")
  `BBLUR_ASSERT_NXT(a_pixel_reaches_q, push && !full && !kind_i, cq_push, "pixel transfer lost")

endmodule

// ===== test/box_blur_3x3_rgb_top_tb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top_tb
// Self-checking bench for the 3x3 RGB box blur. A short directed table is
// run first: frames of one pixel, zero and clamped sizes, a flat white
// frame, and drains sent early or after the frame. Random frames of small
// size follow, some cut short by a register write, then one very tall frame
// and one at full line width, both left unfinished. Every accepted item goes
// through an in-bench model of the filter, and each popped pixel is checked
// field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bblur_pkg::*;

  localparam int LINE_MAX    = 1024;
  localparam int RAND_ITEMS  = 720;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PRINT_MAX   = 100;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_IMG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push        = 1'b0;
  logic                  full;
  logic                  kind_i      = KIND_PIXEL;
  logic [CH_W-1:0]       red_in_i    = '0;
  logic [CH_W-1:0]       green_in_i  = '0;
  logic [CH_W-1:0]       blue_in_i   = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [CH_W-1:0]       red_out_o;
  logic [CH_W-1:0]       green_out_o;
  logic [CH_W-1:0]       blue_out_o;
  logic                  frame_end_o;

  box_blur_3x3_rgb_top #(
    .MAX_LINE (LINE_MAX)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .empty       (empty),
    .pop         (pop),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter model: registers, line buffers, window and raster counters
  // --------------------------------------------------------------------------
  logic [IMG_W_REG_W-1:0] width_reg;
  logic [IMG_H_REG_W-1:0] height_reg;
  pix_t lb_last  [LINE_MAX];   // column of the latest line
  pix_t lb_older [LINE_MAX];   // column of the line before
  pix_t win      [WIN_N];
  int   col_in, row_in, col_out, row_out;

  res_t blur_due_q [$];        // blurred pixels still to come out

  bit   steady = 1'b0;         // no stalls on either side while set
  int   errors, results_seen, items_taken, items_ignored;
  int   cfg_writes, frames_done, pauses, cycles;

  function automatic void frame_restart();
    foreach (win[i]) win[i] = '0;
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  function automatic void blur_reset();
    width_reg  = IMG_W_REG_W'(WIDTH_RST);
    height_reg = IMG_H_REG_W'(HEIGHT_RST);
    foreach (lb_last[i]) begin
      lb_last[i]  = '0;
      lb_older[i] = '0;
    end
    frame_restart();
  endfunction

  function automatic void blur_config(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMG_WIDTH: begin
        width_reg = val[IMG_W_REG_W-1:0];
        frame_restart();
      end
      REG_IMG_HEIGHT: begin
        height_reg = val[IMG_H_REG_W-1:0];
        frame_restart();
      end
      default: ;
    endcase
  endfunction

  function automatic int act_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return int'(width_reg);
  endfunction

  function automatic int act_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // mean over window cells (j, k >= k_low) at frame row base_row + j,
  // frame column base_col + k that fall inside the frame
  function automatic pix_t nb_mean(input int base_row, input int base_col, input int k_low,
                                   input int h, input int w);
    int sr = 0;
    int sg = 0;
    int sb = 0;
    int n  = 0;
    int rr, cc;
    for (int j = 0; j < WIN_SIDE; j++) begin
      rr = base_row + j;
      if (rr >= 0 && rr < h) begin
        for (int k = k_low; k < WIN_SIDE; k++) begin
          cc = base_col + k;
          if (cc >= 0 && cc < w) begin
            sr += win[j*3+k][23:16];
            sg += win[j*3+k][15:8];
            sb += win[j*3+k][7:0];
            n++;
          end
        end
      end
    end
    if (n == 0) return '0;
    return {8'(sr / n), 8'(sg / n), 8'(sb / n)};
  endfunction

  function automatic void blur_step(input logic k, input pix_t px, output bit skip,
                                    output bit made, output res_t res);
    int   w, h, c;
    bit   done, emit, last;
    pix_t data, acc, top, mid;
    w    = act_width();
    h    = act_height();
    done = row_in >= h;
    skip = 1'b0;
    made = 1'b0;
    res  = '0;
    // drain inside a frame is dropped
    if (k == KIND_DRAIN && !done) begin
      skip = 1'b1;
      return;
    end
    data = done ? '0 : px;
    emit = row_in >= 2 || (row_in == 1 && col_in >= 1);
    acc  = '0;
    // at line start the right-edge pixel of the line before uses the old window
    if (emit && col_in == 0) acc = nb_mean(row_in - 3, w - 3, 1, h, w);
    c   = (col_in < LINE_MAX) ? col_in : LINE_MAX - 1;
    top = lb_older[c];
    mid = lb_last[c];
    lb_older[c] = mid;
    lb_last[c]  = data;
    for (int j = 0; j < WIN_SIDE; j++) begin
      win[j*3]   = win[j*3+1];
      win[j*3+1] = win[j*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = data;
    if (emit && col_in >= 1) acc = nb_mean(row_in - 2, col_in - 2, 0, h, w);
    if (col_in + 1 >= w) begin
      col_in = 0;
      row_in++;
    end else begin
      col_in++;
    end
    if (!emit) return;
    last = (row_out + 1 >= h) && (col_out + 1 >= w);
    res  = '{red: acc[23:16], green: acc[15:8], blue: acc[7:0], last: last};
    if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
    if (last) frame_restart();
    made = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic flag(input string msg);
    errors++;
    if (errors <= PRINT_MAX) $display("%0t ns  MISMATCH  %s", $time, msg);
  endtask

  function automatic int idle_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(16, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CH_W-1:0] rand_ch();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pix_t rand_pix();
    return {rand_ch(), rand_ch(), rand_ch()};
  endfunction

  // push stays high after a transfer; anything that waits must drop it first
  task automatic hold_until_drained();
    push <= 1'b0;
    while (blur_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    hold_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    blur_config(idx, val);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_item(input logic k, input pix_t px, input bit typed, input res_t want);
    int   gap;
    bit   skip, made;
    res_t got;
    gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    kind_i     <= k;
    red_in_i   <= px[23:16];
    green_in_i <= px[15:8];
    blue_in_i  <= px[7:0];
    do @(posedge clk_i); while (full);
    blur_step(k, px, skip, made, got);
    if (skip) items_ignored++;
    else items_taken++;
    if (typed) blur_due_q.push_back(want);
    else if (made) blur_due_q.push_back(got);
  endtask

  // one frame at the current size: pixels with stray drains, then the tail unless cut short
  task automatic run_frame(input bit cut_short);
    int w, h, npix, pause_at, stop_at;
    w        = act_width();
    h        = act_height();
    npix     = w * h;
    steady   = ($urandom_range(0, 3) == 0);
    pause_at = (pauses == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, npix - 1) : -1;
    stop_at  = npix;
    if (cut_short && npix > 1) stop_at = $urandom_range(1, (npix > 60) ? 60 : npix - 1);
    for (int i = 0; i < stop_at; i++) begin
      if (i == pause_at) begin
        hold_until_drained();
        pauses++;
      end
      if ($urandom_range(0, 19) == 0) send_item(KIND_DRAIN, rand_pix(), 1'b0, '0);
      send_item(KIND_PIXEL, rand_pix(), 1'b0, '0);
    end
    if (stop_at < npix) return;
    // w + 1 tail items; a pixel here only acts as a drain
    for (int i = 0; i <= w; i++) begin
      send_item(($urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_DRAIN, rand_pix(), 1'b0, '0);
    end
    frames_done++;
    if ($urandom_range(0, 9) == 0) send_item(KIND_DRAIN, rand_pix(), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef enum {ROW_CFG, ROW_ITEM} row_op_e;

  typedef struct {
    row_op_e               op;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  k;
    pix_t                  px;
    bit                    typed;
    res_t                  want;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset size 640x480: drain inside the frame is dropped
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b0, '0},
    '{ROW_CFG,  REG_IMG_WIDTH,  13'd1,     KIND_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_CFG,  REG_IMG_HEIGHT, 13'd1,     KIND_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'hFFFFFF, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b0, '0},
    // pixel after the frame is a drain, its data dropped
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'h123456, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b1,
      '{8'h00, 8'h00, 8'h00, 1'b1}},
    // zero sizes act as one; upper data bits are not part of the width
    '{ROW_CFG,  REG_IMG_WIDTH,  13'h1800,  KIND_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_CFG,  REG_IMG_HEIGHT, 13'd0,     KIND_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'hA55A0F, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b1,
      '{8'hA5, 8'h5A, 8'h0F, 1'b1}},
    // flat white 2x2: every mean is 255
    '{ROW_CFG,  REG_IMG_WIDTH,  13'd2,     KIND_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_CFG,  REG_IMG_HEIGHT, 13'd2,     KIND_PIXEL, 24'h000000, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'hFFFFFF, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'hFFFFFF, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'hFFFFFF, 1'b0, '0},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_PIXEL, 24'hFFFFFF, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
    '{ROW_ITEM, REG_IMG_WIDTH,  13'd0,     KIND_DRAIN, 24'h000000, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 1'b1}}
  };

  // --------------------------------------------------------------------------
  // Result side: check every transfer, stall at random
  // --------------------------------------------------------------------------
  initial begin : result_side
    res_t want;
    int   stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        results_seen++;
        if (blur_due_q.size() == 0) begin
          flag($sformatf("pixel #%0d %02h %02h %02h end=%0b with nothing pending",
                         results_seen, red_out_o, green_out_o, blue_out_o, frame_end_o));
        end else begin
          want = blur_due_q.pop_front();
          if (red_out_o !== want.red)
            flag($sformatf("pixel #%0d red %02h, want %02h", results_seen, red_out_o, want.red));
          if (green_out_o !== want.green)
            flag($sformatf("pixel #%0d green %02h, want %02h", results_seen, green_out_o,
                           want.green));
          if (blue_out_o !== want.blue)
            flag($sformatf("pixel #%0d blue %02h, want %02h", results_seen, blue_out_o,
                           want.blue));
          if (frame_end_o !== want.last)
            flag($sformatf("pixel #%0d frame_end %0b, want %0b", results_seen, frame_end_o,
                           want.last));
        end
      end
      if (steady) begin
        pop <= 1'b1;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        stall = idle_len() - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycles,
               blur_due_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int lap_start, wv, hv, nfr;
    blur_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else send_item(dir_tab[i].k, dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
    end

    lap_start = items_taken;
    while (items_taken - lap_start < RAND_ITEMS) begin
      wv = ($urandom_range(0, 15) == 0) ? 0 :
           $urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 8);
      hv = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
      write_reg(REG_IMG_WIDTH, {2'($urandom_range(0, 3)), 11'(wv)});
      write_reg(REG_IMG_HEIGHT, 13'(hv));
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) run_frame(f == nfr - 1 && $urandom_range(0, 7) == 0);
    end

    // tallest frame, left unfinished
    write_reg(REG_IMG_WIDTH, 13'd3);
    write_reg(REG_IMG_HEIGHT, 13'h1FFF);
    run_frame(1'b1);
    // widest setting, clamps to the line buffer depth; just past one full
    // line so the first results show where the line wraps
    write_reg(REG_IMG_WIDTH, 13'h07FF);
    write_reg(REG_IMG_HEIGHT, 13'd2);
    for (int i = 0; i < LINE_MAX + 64; i++) send_item(KIND_PIXEL, rand_pix(), 1'b0, '0);

    hold_until_drained();
    repeat (4 * SETTLE) @(posedge clk_i);

    $display("sent %0d items (%0d drains dropped), checked %0d blurred pixels",
             items_taken, items_ignored, results_seen);
    $display("%0d random frames, %0d register writes, %0d mid-frame pauses, %0d mismatches",
             frames_done, cfg_writes, pauses, errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bblur_pkg.sv
hdl/bblur_fifo.sv
hdl/bblur_front.sv
hdl/bblur_back.sv
hdl/box_blur_3x3_rgb_top.sv
test/box_blur_3x3_rgb_top_tb.sv
